[rtl/core/all_pairs_shortest_path_defines.svh]
// Assertion macros shared by the shortest path block.
`ifndef ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define APSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define APSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/apsp_pkg.sv]
// Package: shared constants and types of the shortest path block.
package apsp_pkg;

    // Field widths
    localparam int DIST_W  = 14;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 5;
    localparam int COUNT_W = 6;

    // Defaults
    localparam int                 MAX_NODES_DEF  = 32;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 6'd32;

    // Distance meaning "no edge / unreachable"
    localparam logic [DIST_W-1:0] NO_EDGE = 14'd9999;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Register indexes
    localparam logic REG_NODE_COUNT = 1'b0;

    // Closure sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_ROW_RD,
        ST_ROW_WAIT,
        ST_RELAX
    } apsp_state_t;

    // Memory port enables
    typedef struct packed {
        logic wr_en;
        logic rd_a_en;
        logic rd_b_en;
    } apsp_mem_ctl_t;

endpackage

[rtl/core/all_pairs_shortest_path.sv]
// Read transaction: distance passes the memory read register, then the output register.
// Run transaction: busy for a normalize pass over every active entry, then, for each of the
// n*n pivot rows, a pivot hop read and a row relaxation (skipped when the pivot hop is
// unreachable); n = active nodes; one update of one matrix entry per memory cycle.
// A run with zero active nodes completes at once.
// Reset sets node_count to 32 and clears the handshakes; the matrix is not cleared.
`include "all_pairs_shortest_path_defines.svh"

module all_pairs_shortest_path
    import apsp_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [KIND_W-1:0]  kind,
    input  logic [INDEX_W-1:0] row,
    input  logic [INDEX_W-1:0] col,
    input  logic [DIST_W-1:0]  weight,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DIST_W-1:0]  distance,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int AW = 2 * IW;

    logic [COUNT_W-1:0] node_count_reg;
    logic [COUNT_W:0]   ncap;
    logic [IW-1:0]      last_idx;

    logic               in_fire;
    logic               in_range;
    logic               move;
    logic               rd_pend_reg, rd_oob_reg;
    logic               out_valid_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [DIST_W-1:0]  weight_sat;

    logic               eng_start, eng_busy;
    apsp_mem_ctl_t      eng_ctl, host_ctl, mem_ctl;
    logic [AW-1:0]      eng_waddr, eng_raddr_a, eng_raddr_b;
    logic [DIST_W-1:0]  eng_wdata;
    logic [AW-1:0]      host_addr;
    logic [AW-1:0]      waddr, raddr_a, raddr_b;
    logic [DIST_W-1:0]  wdata;
    logic [DIST_W-1:0]  rdata_a, rdata_b;
    logic               eng_wr_ok;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_COUNT) ? {26'd0, node_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT))
        begin
            node_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Active node count, capped at the matrix size
    always_comb
    begin
        if ((COUNT_W+1)'(node_count_reg) > (COUNT_W+1)'(MAX_NODES))
        begin
            ncap = (COUNT_W+1)'(MAX_NODES);
        end
        else
        begin
            ncap = (COUNT_W+1)'(node_count_reg);
        end
        last_idx = IW'(ncap - 1'b1);
    end

    // Input decode
    assign move       = !out_valid_reg || out_ready;
    assign in_ready   = !eng_busy && (!rd_pend_reg || move);
    assign in_fire    = in_valid && in_ready;
    assign in_range   = ((COUNT_W+1)'(row) < (COUNT_W+1)'(MAX_NODES))
                     && ((COUNT_W+1)'(col) < (COUNT_W+1)'(MAX_NODES));
    assign weight_sat = (weight > NO_EDGE) ? NO_EDGE : weight;
    assign host_addr  = {IW'(row), IW'(col)};
    assign eng_start  = in_fire && (kind == KIND_RUN) && (ncap != '0);

    always_comb
    begin
        host_ctl.wr_en   = in_fire && (kind == KIND_WRITE) && in_range;
        host_ctl.rd_a_en = in_fire && (kind == KIND_READ) && in_range;
        host_ctl.rd_b_en = 1'b0;
    end

    // Memory port ownership: sequencer while a run is active
    always_comb
    begin
        if (eng_busy)
        begin
            mem_ctl = eng_ctl;
            waddr   = eng_waddr;
            wdata   = eng_wdata;
            raddr_a = eng_raddr_a;
            raddr_b = eng_raddr_b;
        end
        else
        begin
            mem_ctl = host_ctl;
            waddr   = host_addr;
            wdata   = weight_sat;
            raddr_a = host_addr;
            raddr_b = host_addr;
        end
    end

    apsp_mem #(
        .AW (AW)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    apsp_engine #(
        .MAX_NODES (MAX_NODES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (eng_start),
        .last_idx (last_idx),
        .busy     (eng_busy),
        .mem_ctl  (eng_ctl),
        .waddr    (eng_waddr),
        .wdata    (eng_wdata),
        .raddr_a  (eng_raddr_a),
        .raddr_b  (eng_raddr_b),
        .rdata_a  (rdata_a),
        .rdata_b  (rdata_b)
    );

    // Read result: held in the memory read register until the output takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire && (kind == KIND_READ))
            begin
                rd_pend_reg <= 1'b1;
            end
            else if (move)
            begin
                rd_pend_reg <= 1'b0;
            end
            if (rd_pend_reg && move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (kind == KIND_READ))
        begin
            rd_oob_reg <= !in_range;
        end
        if (rd_pend_reg && move)
        begin
            dist_reg <= rd_oob_reg ? NO_EDGE : rdata_a;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = dist_reg;

    // Checks
    assign eng_wr_ok = (eng_waddr[AW-1:IW] <= last_idx) && (eng_waddr[IW-1:0] <= last_idx);

    `APSP_ASSERT_NEXT(a_run_starts, eng_start, eng_busy, "run did not start sequencer")
    `APSP_ASSERT_NOW(a_pend_idle, rd_pend_reg, !eng_busy, "read result pending during a run")
    `APSP_ASSERT_NOW(a_wr_in_block, eng_busy && eng_ctl.wr_en, eng_wr_ok, "run wrote outside block")

endmodule

[rtl/core/apsp_mem.sv]
// Distance matrix memory: one write port, two registered read ports.
module apsp_mem
    import apsp_pkg::*;
#(
    parameter int AW = 10
)
(
    input  logic              clk,
    input  apsp_mem_ctl_t     ctl,
    input  logic [AW-1:0]     waddr,
    input  logic [DIST_W-1:0] wdata,
    input  logic [AW-1:0]     raddr_a,
    input  logic [AW-1:0]     raddr_b,
    output logic [DIST_W-1:0] rdata_a,
    output logic [DIST_W-1:0] rdata_b
);

    logic [DIST_W-1:0] mem [2**AW];

    // Write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, write data forwarded on an address match
    always_ff @(posedge clk)
    begin
        if (ctl.rd_a_en)
        begin
            if (ctl.wr_en && (waddr == raddr_a))
            begin
                rdata_a <= wdata;
            end
            else
            begin
                rdata_a <= mem[raddr_a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_b_en)
        begin
            if (ctl.wr_en && (waddr == raddr_b))
            begin
                rdata_b <= wdata;
            end
            else
            begin
                rdata_b <= mem[raddr_b];
            end
        end
    end

endmodule

[rtl/core/apsp_engine.sv]
// Closure sequencer: normalize pass, then k/i/j relaxation over the memory.
module apsp_engine
    import apsp_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [$clog2(MAX_NODES)-1:0]        last_idx,
    output logic                                busy,
    output apsp_mem_ctl_t                       mem_ctl,
    output logic [2*$clog2(MAX_NODES)-1:0]      waddr,
    output logic [DIST_W-1:0]                   wdata,
    output logic [2*$clog2(MAX_NODES)-1:0]      raddr_a,
    output logic [2*$clog2(MAX_NODES)-1:0]      raddr_b,
    input  logic [DIST_W-1:0]                   rdata_a,
    input  logic [DIST_W-1:0]                   rdata_b
);

    localparam int IW = $clog2(MAX_NODES);

    apsp_state_t       state_reg, state_next;
    logic [IW-1:0]     i_reg, i_next;
    logic [IW-1:0]     j_reg, j_next;
    logic [IW-1:0]     k_reg, k_next;
    logic [DIST_W-1:0] a_reg, a_next;

    // Update stage: one read-modify-write in flight
    logic              pv_reg, pv_next;
    logic              prelax_reg, prelax_next;
    logic [IW-1:0]     pr_reg, pc_reg;

    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] sum_sat;
    logic [DIST_W-1:0] norm_val;
    logic              relax_wr;

    // Sequencer next state and loop counters
    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        a_next      = a_reg;
        pv_next     = 1'b0;
        prelax_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_NORM;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_NORM:
            begin
                pv_next = 1'b1;
                if (j_reg == last_idx)
                begin
                    j_next = '0;
                    if (i_reg == last_idx)
                    begin
                        i_next     = '0;
                        state_next = ST_ROW_RD;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_ROW_RD:
            begin
                state_next = ST_ROW_WAIT;
            end
            ST_ROW_WAIT:
            begin
                a_next = rdata_a;
                j_next = '0;
                if (rdata_a >= NO_EDGE)
                begin
                    // unreachable pivot hop: skip the row
                    if (i_reg == last_idx)
                    begin
                        i_next = '0;
                        if (k_reg == last_idx)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            k_next     = k_reg + 1'b1;
                            state_next = ST_ROW_RD;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_ROW_RD;
                    end
                end
                else
                begin
                    state_next = ST_RELAX;
                end
            end
            ST_RELAX:
            begin
                pv_next     = 1'b1;
                prelax_next = 1'b1;
                if (j_reg == last_idx)
                begin
                    j_next = '0;
                    if (i_reg == last_idx)
                    begin
                        i_next = '0;
                        if (k_reg == last_idx)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            k_next     = k_reg + 1'b1;
                            state_next = ST_ROW_RD;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_ROW_RD;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Update stage arithmetic
    always_comb
    begin
        sum      = {1'b0, a_reg} + {1'b0, rdata_a};
        sum_sat  = (sum > {1'b0, NO_EDGE}) ? NO_EDGE : sum[DIST_W-1:0];
        relax_wr = (rdata_a < NO_EDGE) && (sum_sat < rdata_b);
        if (pr_reg == pc_reg)
        begin
            norm_val = '0;
        end
        else if ((rdata_a == '0) || (rdata_a >= NO_EDGE))
        begin
            norm_val = NO_EDGE;
        end
        else
        begin
            norm_val = rdata_a;
        end
    end

    // Memory requests
    always_comb
    begin
        mem_ctl.rd_a_en = 1'b0;
        mem_ctl.rd_b_en = 1'b0;
        raddr_a         = {i_reg, j_reg};
        raddr_b         = {i_reg, j_reg};
        unique case (state_reg)
            ST_NORM:
            begin
                mem_ctl.rd_a_en = 1'b1;
            end
            ST_ROW_RD:
            begin
                mem_ctl.rd_a_en = 1'b1;
                raddr_a         = {i_reg, k_reg};
            end
            ST_RELAX:
            begin
                mem_ctl.rd_a_en = 1'b1;
                mem_ctl.rd_b_en = 1'b1;
                raddr_a         = {k_reg, j_reg};
            end
            default:
            begin
                mem_ctl.rd_a_en = 1'b0;
            end
        endcase
        waddr = {pr_reg, pc_reg};
        if (prelax_reg)
        begin
            mem_ctl.wr_en = pv_reg && relax_wr;
            wdata         = sum_sat;
        end
        else
        begin
            mem_ctl.wr_en = pv_reg;
            wdata         = norm_val;
        end
        busy = (state_reg != ST_IDLE) || pv_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            pv_reg     <= 1'b0;
            prelax_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            pv_reg     <= pv_next;
            prelax_reg <= prelax_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        pr_reg <= i_reg;
        pc_reg <= j_reg;
    end

endmodule
